// ----- hdl/mit_pkg.sv -----
package mit_pkg;

   localparam int INDEX_BITS = 24;
   localparam int CoefW = 21;
   localparam int RowW = 3 * CoefW;
   localparam int PosW = 32;
   localparam int NrmW = 16;
   localparam int MatW = 15;
   localparam int DataW = ((3 * PosW + 3 * NrmW + 3 * INDEX_BITS + MatW + 7) / 8) * 8;

   localparam int MagW = 30;
   localparam int SqW = 2 * MagW;
   localparam int SumSqW = SqW + 2;
   localparam int RootW = SumSqW / 2;
   localparam int QuoW = 15;
   localparam int NumW = MagW + QuoW;

   localparam int SqrtSteps = RootW;
   localparam int DivStages = QuoW + 1;

   localparam int StMul = 0;
   localparam int StSum = 1;
   localparam int StRnd = 2;
   localparam int StSqr = 3;
   localparam int StSqs = 4;
   localparam int StRoot = 5;
   localparam int StDiv = StRoot + SqrtSteps;
   localparam int StOut = StDiv + DivStages;
   localparam int Depth = StOut + 1;

   typedef enum logic [2:0] {
      CsrCoefX    = 3'd0,
      CsrCoefY    = 3'd1,
      CsrCoefZ    = 3'd2,
      CsrOriginX  = 3'd3,
      CsrOriginY  = 3'd4,
      CsrOriginZ  = 3'd5,
      CsrBase     = 3'd6,
      CsrMaterial = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [2:0][MagW-1:0] mag;
      logic [2:0]           neg;
   } nvec_type;

endpackage

// ----- hdl/mit_isqrt.sv -----
module mit_isqrt (
   input  logic                           clock,
   input  logic [mit_pkg::SqrtSteps-1:0]  en,
   input  logic [mit_pkg::SumSqW-1:0]     sq_sum,
   input  mit_pkg::nvec_type              vec_in,
   output logic [mit_pkg::RootW-1:0]      root,
   output mit_pkg::nvec_type              vec_out
);
   import mit_pkg::*;

   localparam int TrialW = SumSqW + 2;

   logic [SumSqW-1:0] rem_ff  [SqrtSteps];
   logic [RootW-1:0]  root_ff [SqrtSteps];
   nvec_type          vec_ff  [SqrtSteps];

   for (genvar j = 0; j < SqrtSteps; j++) begin : g_step
      localparam int Bit = RootW - 1 - j;
      logic [SumSqW-1:0] rem_prev;
      logic [RootW-1:0]  root_prev;
      nvec_type          vec_prev;
      logic [TrialW-1:0] trial;
      logic              fits;
      logic [SumSqW-1:0] rem_in;
      logic [RootW-1:0]  root_in;

      if (j == 0) begin : g_first
         assign rem_prev  = sq_sum;
         assign root_prev = '0;
         assign vec_prev  = vec_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign root_prev = root_ff[j-1];
         assign vec_prev  = vec_ff[j-1];
      end

      assign trial = (TrialW'(root_prev) << (Bit + 1)) | (TrialW'(1) << (2 * Bit));
      assign fits  = TrialW'(rem_prev) >= trial;

      always_comb begin
         rem_in  = rem_prev;
         root_in = root_prev;
         if (fits) begin
            rem_in  = rem_prev - trial[SumSqW-1:0];
            root_in = root_prev | (RootW'(1) << Bit);
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            rem_ff[j]  <= rem_in;
            root_ff[j] <= root_in;
            vec_ff[j]  <= vec_prev;
         end
      end
   end

   assign root    = root_ff[SqrtSteps-1];
   assign vec_out = vec_ff[SqrtSteps-1];

endmodule

// ----- hdl/mit_ndiv.sv -----
module mit_ndiv (
   input  logic                                 clock,
   input  logic [mit_pkg::DivStages-1:0]        en,
   input  logic [mit_pkg::RootW-1:0]            root,
   input  mit_pkg::nvec_type                    vec_in,
   output logic [2:0][mit_pkg::QuoW-1:0]        quo,
   output logic [2:0]                           neg,
   output logic                                 len_zero
);
   import mit_pkg::*;

   logic [2:0][NumW-1:0] num_ff  [DivStages];
   logic [2:0][QuoW-1:0] quo_ff  [DivStages];
   logic [RootW-1:0]     len_ff  [DivStages];
   logic [2:0]           neg_ff  [DivStages];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int l = 0; l < 3; l++) begin
            num_ff[0][l] <= {vec_in.mag[l], {QuoW-1{1'b0}}} + NumW'(root >> 1);
         end
         quo_ff[0] <= '0;
         len_ff[0] <= root;
         neg_ff[0] <= vec_in.neg;
      end
   end

   for (genvar j = 1; j < DivStages; j++) begin : g_step
      localparam int Bit = QuoW - j;
      logic [NumW-1:0]      trial;
      logic [2:0][NumW-1:0] num_in;
      logic [2:0][QuoW-1:0] quo_in;

      assign trial = NumW'(len_ff[j-1]) << Bit;

      always_comb begin
         num_in = num_ff[j-1];
         quo_in = quo_ff[j-1];
         for (int l = 0; l < 3; l++) begin
            if (num_ff[j-1][l] >= trial) begin
               num_in[l] = num_ff[j-1][l] - trial;
               quo_in[l] = quo_ff[j-1][l] | (QuoW'(1) << Bit);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            num_ff[j] <= num_in;
            quo_ff[j] <= quo_in;
            len_ff[j] <= len_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
         end
      end
   end

   assign quo      = quo_ff[DivStages-1];
   assign neg      = neg_ff[DivStages-1];
   assign len_zero = (len_ff[DivStages-1] == '0);

endmodule

// ----- hdl/mesh_instance_transform.sv -----
// Throughput: one transaction per cycle unless a stalled response backs up the
// pipeline; the 31-step square root and the 15-step divider (after a rounding setup
// stage) are fully pipelined, one result bit per step.
// A stalled response only holds the stages that are full; empty stages keep filling.
// Reset (synchronous, active high) empties the pipeline and loads the identity
// matrix, zero origin and base, and a material override of -1.
module mesh_instance_transform (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, corner_a, corner_b, corner_c,
   // material_in, zero pad
   input  logic [mit_pkg::DataW-1:0]   req_tdata,
   // operation
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y, out_nrm_z,
   // out_corner_a, out_corner_b, out_corner_c, material_out, zero pad
   output logic [mit_pkg::DataW-1:0]   rsp_tdata,
   // kind_out
   output logic                        rsp_tuser,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [2:0]                  csr_index,
   input  logic [mit_pkg::RowW-1:0]    csr_data
);
   import mit_pkg::*;

   typedef struct packed {
      logic                             kind;
      logic [2:0][PosW-1:0]             pos;
      logic [2:0][INDEX_BITS-1:0]       corner;
      logic [MatW-1:0]                  material;
   } carry_type;

   logic [2:0][RowW-1:0]   coef_ff;
   logic [2:0][PosW-1:0]   origin_ff;
   logic [INDEX_BITS-1:0]  base_ff;
   logic [15:0]            override_ff;

   logic [Depth-1:0]       valid_ff;
   logic [Depth-1:0]       valid_in;
   logic [Depth:0]         en;
   carry_type              carry_ff [Depth];
   carry_type              carry_in;
   carry_type              carry_rnd;

   logic signed [PosW-1:0] pos_in [3];
   logic signed [NrmW-1:0] nrm_in [3];
   logic [INDEX_BITS-1:0]  corner_in [3];

   logic signed [CoefW+PosW-1:0]   pprod_ff [3][3];
   logic signed [CoefW+NrmW-1:0]   nprod_ff [3][3];
   logic signed [CoefW+PosW+1:0]   psum_ff [3];
   logic signed [CoefW+NrmW+1:0]   nsum_ff [3];
   nvec_type                       vec_rnd_ff, vec_sqr_ff, vec_sqs_ff;
   nvec_type                       vec_rnd_in;
   logic [2:0][SqW-1:0]            sq_ff;
   logic [SumSqW-1:0]              sqsum_ff;
   logic [RootW-1:0]               root;
   nvec_type                       vec_root;
   logic [2:0][QuoW-1:0]           quo;
   logic [2:0]                     quo_neg;
   logic                           len_zero;
   logic [2:0][NrmW-1:0]           nrm_out_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]   <= RowW'(1) << 16;
         coef_ff[1]   <= RowW'(1) << (CoefW + 16);
         coef_ff[2]   <= RowW'(1) << (2 * CoefW + 16);
         origin_ff    <= '0;
         base_ff      <= '0;
         override_ff  <= '1;
      end else if (csr_valid) begin
         case (csr_index)
            CsrCoefX:    coef_ff[0]   <= csr_data;
            CsrCoefY:    coef_ff[1]   <= csr_data;
            CsrCoefZ:    coef_ff[2]   <= csr_data;
            CsrOriginX:  origin_ff[0] <= csr_data[PosW-1:0];
            CsrOriginY:  origin_ff[1] <= csr_data[PosW-1:0];
            CsrOriginZ:  origin_ff[2] <= csr_data[PosW-1:0];
            CsrBase:     base_ff      <= csr_data[INDEX_BITS-1:0];
            CsrMaterial: override_ff  <= csr_data[15:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      en[Depth] = rsp_tready;
      for (int k = Depth - 1; k >= 0; k--) begin
         en[k] = !valid_ff[k] | en[k+1];
      end
   end

   assign req_tready = en[0];
   assign valid_in   = {valid_ff[Depth-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Depth; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   always_comb begin
      logic [INDEX_BITS:0] isum;
      isum = '0;
      for (int l = 0; l < 3; l++) begin
         pos_in[l]    = req_tdata[l*PosW +: PosW];
         nrm_in[l]    = req_tdata[3*PosW + l*NrmW +: NrmW];
         corner_in[l] = req_tdata[3*PosW + 3*NrmW + l*INDEX_BITS +: INDEX_BITS];
      end
      carry_in      = '0;
      carry_in.kind = req_tuser;
      if (req_tuser) begin
         for (int l = 0; l < 3; l++) begin
            isum = {1'b0, corner_in[l]} + {1'b0, base_ff};
            carry_in.corner[l] = isum[INDEX_BITS] ? '1 : isum[INDEX_BITS-1:0];
         end
         carry_in.material = override_ff[15] ?
            req_tdata[3*PosW + 3*NrmW + 3*INDEX_BITS +: MatW] : override_ff[MatW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[StMul]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               pprod_ff[r][c] <= $signed(coef_ff[r][c*CoefW +: CoefW]) * pos_in[c];
               nprod_ff[r][c] <= $signed(coef_ff[r][c*CoefW +: CoefW]) * nrm_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[StSum]) begin
         for (int r = 0; r < 3; r++) begin
            psum_ff[r] <= (CoefW+PosW+2)'(pprod_ff[r][0]) + (CoefW+PosW+2)'(pprod_ff[r][1])
                        + (CoefW+PosW+2)'(pprod_ff[r][2]);
            nsum_ff[r] <= (CoefW+NrmW+2)'(nprod_ff[r][0]) + (CoefW+NrmW+2)'(nprod_ff[r][1])
                        + (CoefW+NrmW+2)'(nprod_ff[r][2]);
         end
      end
   end

   always_comb begin
      logic signed [CoefW+PosW+1:0] pr;
      logic signed [PosW+7:0]       pt;
      logic signed [CoefW+NrmW+1:0] nr;
      logic signed [CoefW+NrmW+1:0] na;
      carry_rnd  = carry_ff[StRnd-1];
      vec_rnd_in = '0;
      for (int r = 0; r < 3; r++) begin
         pr = (psum_ff[r] + (CoefW+PosW+2)'(32768)) >>> 16;
         pt = (PosW+8)'(pr) + (PosW+8)'($signed(origin_ff[r]));
         if (carry_ff[StRnd-1].kind) begin
            carry_rnd.pos[r] = '0;
         end else if (pt > (PosW+8)'(32'sh7fffffff)) begin
            carry_rnd.pos[r] = 32'h7fffffff;
         end else if (pt < (PosW+8)'(-33'sh80000000)) begin
            carry_rnd.pos[r] = 32'h80000000;
         end else begin
            carry_rnd.pos[r] = pt[PosW-1:0];
         end
         nr = (nsum_ff[r] + (CoefW+NrmW+2)'(64)) >>> 7;
         na = nr[CoefW+NrmW+1] ? -nr : nr;
         vec_rnd_in.neg[r] = nr[CoefW+NrmW+1];
         vec_rnd_in.mag[r] = na[MagW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[StRnd]) begin
         vec_rnd_ff <= vec_rnd_in;
      end
      if (en[StSqr]) begin
         for (int r = 0; r < 3; r++) begin
            sq_ff[r] <= vec_rnd_ff.mag[r] * vec_rnd_ff.mag[r];
         end
         vec_sqr_ff <= vec_rnd_ff;
      end
      if (en[StSqs]) begin
         sqsum_ff   <= SumSqW'(sq_ff[0]) + SumSqW'(sq_ff[1]) + SumSqW'(sq_ff[2]);
         vec_sqs_ff <= vec_sqr_ff;
      end
   end

   for (genvar k = 0; k < Depth; k++) begin : g_carry
      always_ff @(posedge clock) begin
         if (en[k]) begin
            if (k == StMul) begin
               carry_ff[k] <= carry_in;
            end else if (k == StRnd) begin
               carry_ff[k] <= carry_rnd;
            end else begin
               carry_ff[k] <= carry_ff[(k == 0) ? 0 : k-1];
            end
         end
      end
   end

   mit_isqrt u_isqrt (
      .clock   (clock),
      .en      (en[StRoot +: SqrtSteps]),
      .sq_sum  (sqsum_ff),
      .vec_in  (vec_sqs_ff),
      .root    (root),
      .vec_out (vec_root)
   );

   mit_ndiv u_ndiv (
      .clock    (clock),
      .en       (en[StDiv +: DivStages]),
      .root     (root),
      .vec_in   (vec_root),
      .quo      (quo),
      .neg      (quo_neg),
      .len_zero (len_zero)
   );

   always_ff @(posedge clock) begin
      if (en[StOut]) begin
         for (int r = 0; r < 3; r++) begin
            if (carry_ff[StOut-1].kind || len_zero) begin
               nrm_out_ff[r] <= '0;
            end else if (quo_neg[r]) begin
               nrm_out_ff[r] <= -NrmW'(quo[r]);
            end else begin
               nrm_out_ff[r] <= NrmW'(quo[r]);
            end
         end
      end
   end

   assign rsp_tvalid = valid_ff[Depth-1];
   assign rsp_tuser  = carry_ff[Depth-1].kind;
   assign rsp_tdata  = {1'b0, carry_ff[Depth-1].material, carry_ff[Depth-1].corner,
                        nrm_out_ff, carry_ff[Depth-1].pos};

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> valid_ff[0])
      else $error("input stalled while the first stage is empty");

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_unit_normal : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(nrm_out_ff[0]) <= 16'sd16384 && $signed(nrm_out_ff[0]) >= -16'sd16384 &&
          $signed(nrm_out_ff[1]) <= 16'sd16384 && $signed(nrm_out_ff[1]) >= -16'sd16384 &&
          $signed(nrm_out_ff[2]) <= 16'sd16384 && $signed(nrm_out_ff[2]) >= -16'sd16384))
      else $error("renormalized normal component out of range");

endmodule

// ----- dv/mesh_instance_transform_test.sv -----
`timescale 1ns / 1ps

module mesh_instance_transform_test;
   import mit_pkg::*;

   localparam int CycleLimit = 400000;
   localparam longint IndexMax = (64'd1 << INDEX_BITS) - 1;

   typedef struct packed {
      logic              kind;
      logic [31:0]       px, py, pz;
      logic [15:0]       nx, ny, nz;
      logic [23:0]       ca, cb, cc;
      logic [14:0]       mat;
   } mesh_item_type;

   class instance_scoreboard_type;
      logic [RowW-1:0] row [3];
      longint          org [3];
      longint          base;
      longint          mat_ovr;
      mesh_item_type   pending [$];
      int              errors;

      function new();
         row[0] = 63'd1 << 16;
         row[1] = 63'd1 << (CoefW + 16);
         row[2] = 63'd1 << (2 * CoefW + 16);
         org = '{0, 0, 0};
         base = 0;
         mat_ovr = -1;
         errors = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [RowW-1:0] val);
         case (idx)
            CsrCoefX: row[0] = val;
            CsrCoefY: row[1] = val;
            CsrCoefZ: row[2] = val;
            CsrOriginX: org[0] = longint'(signed'(val[31:0]));
            CsrOriginY: org[1] = longint'(signed'(val[31:0]));
            CsrOriginZ: org[2] = longint'(signed'(val[31:0]));
            CsrBase: base = val[23:0];
            CsrMaterial: mat_ovr = longint'(signed'(val[15:0]));
            default: ;
         endcase
      endfunction

      function longint coef(int r, int k);
         logic [CoefW-1:0] c;
         c = row[r][k*CoefW +: CoefW];
         return longint'(signed'(c));
      endfunction

      function longint floor_div_pow2(longint x, int s);
         return x >>> s;
      endfunction

      function longint isqrt(longint s);
         longint r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > s) b = b >> 2;
         while (b != 0) begin
            if (s >= r + b) begin
               s = s - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [15:0] unit_comp(longint v, longint len);
         longint mag, q;
         if (len == 0) return 16'd0;
         mag = v < 0 ? -v : v;
         q = (mag * 16384 + len / 2) / len;
         if (v < 0) q = -q;
         return q[15:0];
      endfunction

      function logic [23:0] add_index(logic [23:0] c);
         longint s;
         s = longint'(c) + base;
         return s > IndexMax ? IndexMax[23:0] : s[23:0];
      endfunction

      function void note_request(mesh_item_type it);
         mesh_item_type e;
         longint p [3], n [3], v [3], t, len;
         e = '{default: '0};
         e.kind = it.kind;
         if (!it.kind) begin
            p = '{longint'(signed'(it.px)), longint'(signed'(it.py)), longint'(signed'(it.pz))};
            n = '{longint'(signed'(it.nx)), longint'(signed'(it.ny)), longint'(signed'(it.nz))};
            for (int r = 0; r < 3; r++) begin
               t = coef(r, 0) * p[0] + coef(r, 1) * p[1] + coef(r, 2) * p[2];
               t = floor_div_pow2(t + 32768, 16) + org[r];
               if (t > 2147483647) t = 2147483647;
               if (t < -64'sd2147483648) t = -64'sd2147483648;
               if (r == 0) e.px = t[31:0];
               else if (r == 1) e.py = t[31:0];
               else e.pz = t[31:0];
               t = coef(r, 0) * n[0] + coef(r, 1) * n[1] + coef(r, 2) * n[2];
               v[r] = floor_div_pow2(t + 64, 7);
            end
            len = isqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
            e.nx = unit_comp(v[0], len);
            e.ny = unit_comp(v[1], len);
            e.nz = unit_comp(v[2], len);
         end else begin
            e.ca = add_index(it.ca);
            e.cb = add_index(it.cb);
            e.cc = add_index(it.cc);
            e.mat = mat_ovr >= 0 ? mat_ovr[14:0] : it.mat;
         end
         pending.push_back(e);
      endfunction

      function void check_response(mesh_item_type got);
         mesh_item_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response transaction", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got != e) begin
            $display("%0t: mismatch expected k=%0d pos=%h %h %h nrm=%h %h %h idx=%h %h %h m=%h",
                     $time, e.kind, e.px, e.py, e.pz, e.nx, e.ny, e.nz,
                     e.ca, e.cb, e.cc, e.mat);
            $display("%0t: mismatch actual   k=%0d pos=%h %h %h nrm=%h %h %h idx=%h %h %h m=%h",
                     $time, got.kind, got.px, got.py, got.pz, got.nx, got.ny, got.nz,
                     got.ca, got.cb, got.cc, got.mat);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DataW-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DataW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [RowW-1:0] csr_data = '0;

   instance_scoreboard_type sb = new();
   int cycles = 0;
   bit hold_rsp = 1'b0;

   mesh_instance_transform u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic logic [DataW-1:0] pack_item(mesh_item_type it);
      return {1'b0, it.mat, it.cc, it.cb, it.ca, it.nz, it.ny, it.nx, it.pz, it.py, it.px};
   endfunction

   always @(posedge clock) begin
      mesh_item_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         {g.mat, g.cc, g.cb, g.ca, g.nz, g.ny, g.nx, g.pz, g.py, g.px} = rsp_tdata[230:0];
         g.kind = rsp_tuser;
         sb.check_response(g);
      end
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   initial begin
      int g;
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            @(negedge clock);
         end else begin
            g = gap_len();
            rsp_tready = (g == 0);
            repeat (g > 0 ? g : 1) @(negedge clock);
         end
      end
   end

   task automatic write_csr(csr_index_type idx, logic [RowW-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_item(mesh_item_type it, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = it.kind;
      req_tdata = pack_item(it);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(it);
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   function automatic logic [15:0] rand_nrm();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'($urandom());
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic mesh_item_type rand_item();
      mesh_item_type it;
      it.kind = 1'($urandom_range(0, 1));
      it.px = $urandom();
      it.py = $urandom();
      it.pz = $urandom();
      if ($urandom_range(0, 3) == 0) begin
         it.px = $signed(it.px) >>> 12;
         it.py = $signed(it.py) >>> 12;
      end
      it.nx = rand_nrm();
      it.ny = rand_nrm();
      it.nz = rand_nrm();
      if ($urandom_range(0, 19) == 0) {it.nx, it.ny, it.nz} = '0;
      it.ca = 24'($urandom());
      it.cb = 24'($urandom());
      it.cc = 24'($urandom());
      it.mat = 15'($urandom());
      return it;
   endfunction

   function automatic logic [CoefW-1:0] rand_coef();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return 21'h100000;
      if (r == 1) return 21'h0fffff;
      if (r == 2) return 21'd0;
      return 21'($signed($urandom_range(0, 262144)) - 131072);
   endfunction

   task automatic random_setting(int mode);
      for (int r = 0; r < 3; r++)
         write_csr(csr_index_type'(CsrCoefX + r),
                   {rand_coef(), rand_coef(), rand_coef()});
      write_csr(CsrOriginX, mode == 1 ? 63'h7fffffff : 63'($urandom()));
      write_csr(CsrOriginY, mode == 1 ? 63'h80000000 : 63'($urandom()));
      write_csr(CsrOriginZ, 63'($urandom_range(0, 65535)));
      write_csr(CsrBase, mode == 1 ? 63'hffffff : 63'($urandom_range(0, 1 << 20)));
      write_csr(CsrMaterial, mode == 2 ? 63'hffff : 63'($urandom_range(0, 32767)));
   endtask

   initial begin
      mesh_item_type it;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      it = '{default: '0};
      send_item(it, 0);
      it.kind = 1'b1;
      send_item(it, 0);
      it = '{kind: 0, px: 32'h7fffffff, py: 32'h80000000, pz: 32'hffffffff,
             nx: 16'h4000, ny: 16'hc000, nz: 16'h0, ca: '0, cb: '0, cc: '0, mat: '0};
      send_item(it, 0);
      it = '{kind: 0, px: 32'h80000000, py: 32'h7fffffff, pz: 32'h1,
             nx: 16'h7fff, ny: 16'h8000, nz: 16'hffff, ca: '0, cb: '0, cc: '0, mat: '0};
      send_item(it, 0);
      it = '{kind: 1, px: '0, py: '0, pz: '0, nx: '0, ny: '0, nz: '0,
             ca: 24'hffffff, cb: 24'h0, cc: 24'h7fffff, mat: 15'h7fff};
      send_item(it, 0);
      drain();
      write_csr(CsrCoefX, {21'h0fffff, 21'h0fffff, 21'h0fffff});
      write_csr(CsrCoefY, {21'h100000, 21'h100000, 21'h100000});
      write_csr(CsrCoefZ, '0);
      write_csr(CsrOriginX, 63'h7fffffff);
      write_csr(CsrOriginY, 63'h80000000);
      write_csr(CsrOriginZ, 63'h1);
      write_csr(CsrBase, 63'hffffff);
      write_csr(CsrMaterial, 63'h0);
      it = '{kind: 0, px: 32'h7fffffff, py: 32'h7fffffff, pz: 32'h7fffffff,
             nx: 16'h4000, ny: 16'h4000, nz: 16'h4000, ca: '0, cb: '0, cc: '0, mat: '0};
      send_item(it, 0);
      it.px = 32'h80000000; it.py = 32'h80000000; it.pz = 32'h80000000;
      it.nx = 16'hc000; it.ny = 16'hc000; it.nz = 16'hc000;
      send_item(it, 0);
      it = '{kind: 1, px: '0, py: '0, pz: '0, nx: '0, ny: '0, nz: '0,
             ca: 24'h1, cb: 24'h0, cc: 24'hffffff, mat: 15'h1234};
      send_item(it, 0);
      drain();
      write_csr(CsrBase, 63'h0);
      write_csr(CsrMaterial, 63'h7fff);
      send_item(it, 0);
      drain();
      write_csr(CsrMaterial, 63'h8000);
      send_item(it, 0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         random_setting(phase % 3);
         if (phase == 2) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (300) @(negedge clock);
                  hold_rsp = 1'b0;
               end
               for (int i = 0; i < 120; i++) send_item(rand_item(), 0);
            join
         end
         for (int i = 0; i < 220; i++) send_item(rand_item(), phase != 4);
      end
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
